>>> rtl/utf8_validating_decoder_core_defines.svh
// Assertion macros shared by the UTF-8 decoder checker.
// Depends on nothing; included by the checker file only.
`ifndef UTF8_VALIDATING_DECODER_CORE_DEFINES_SVH
`define UTF8_VALIDATING_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define U8DEC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("u8dec check failed");

// Next-cycle implication, disabled while reset is high.
`define U8DEC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("u8dec check failed");

`endif

>>> rtl/u8dec_pkg.sv
// Shared types, constants and per-byte helper functions of the UTF-8 decoder.
// Depends on nothing; used by u8dec_step, u8dec_rspq and the top level.
`default_nettype none

package u8dec_pkg;

   localparam int unsigned Q_DEPTH = 4;
   localparam int unsigned Q_AW    = 2;

   localparam logic [7:0] ASCII_LIMIT  = 8'h80;
   localparam logic [7:0] LEAD_MIN     = 8'hC2;
   localparam logic [7:0] LEAD_MAX     = 8'hF4;
   localparam logic [7:0] LEAD_E0      = 8'hE0;
   localparam logic [7:0] LEAD_ED      = 8'hED;
   localparam logic [7:0] LEAD_F0      = 8'hF0;
   localparam logic [7:0] CONT_LO      = 8'h80;
   localparam logic [7:0] CONT_HI      = 8'hBF;
   localparam logic [7:0] SECOND_LO_E0 = 8'hA0;
   localparam logic [7:0] SECOND_HI_ED = 8'h9F;
   localparam logic [7:0] SECOND_LO_F0 = 8'h90;
   localparam logic [7:0] SECOND_HI_F4 = 8'h8F;
   localparam logic [7:0] MASK_2       = 8'h1F;
   localparam logic [7:0] MASK_3       = 8'h0F;
   localparam logic [7:0] MASK_4       = 8'h07;
   localparam logic [1:0] CONT_TAG     = 2'b10;

   typedef struct packed {
      logic [20:0] code_point;
      logic [2:0]  byte_count;
      logic        is_error;
      logic        last_of_run;
   } result_type;

   typedef struct packed {
      logic [2:0]  bytes_needed;
      logic [2:0]  bytes_seen;
      logic [7:0]  lead_byte;
      logic [20:0] partial_value;
   } seq_state_type;

   typedef struct packed {
      logic          has_result;
      result_type    result;
      seq_state_type seq;
   } lead_type;

   // Second-byte window from the well-formed byte table.
   function automatic logic second_ok(logic [7:0] lead, logic [7:0] b);
      logic [7:0] lo;
      logic [7:0] hi;
      lo = CONT_LO;
      hi = CONT_HI;
      if (lead == LEAD_E0) begin
         lo = SECOND_LO_E0;
      end else if (lead == LEAD_ED) begin
         hi = SECOND_HI_ED;
      end else if (lead == LEAD_F0) begin
         lo = SECOND_LO_F0;
      end else if (lead == LEAD_MAX) begin
         hi = SECOND_HI_F4;
      end
      return (b >= lo) && (b <= hi);
   endfunction

   // Treat a byte as the start of a sequence. Either one result comes out
   // (seq stays closed) or a new sequence opens (no result).
   function automatic lead_type take_lead(logic [7:0] b, logic buf_end);
      lead_type   t;
      logic [2:0] n;
      logic [7:0] mask;
      t    = '0;
      n    = 3'd2;
      mask = MASK_2;
      if (b < ASCII_LIMIT) begin
         t.has_result             = 1'b1;
         t.result.code_point      = {13'd0, b};
         t.result.byte_count      = 3'd1;
         t.result.last_of_run     = 1'b1;
      end else if ((b < LEAD_MIN) || (b > LEAD_MAX)) begin
         t.has_result             = 1'b1;
         t.result.byte_count      = 3'd1;
         t.result.is_error        = 1'b1;
         t.result.last_of_run     = 1'b1;
      end else begin
         if (b < LEAD_E0) begin
            n    = 3'd2;
            mask = MASK_2;
         end else if (b < LEAD_F0) begin
            n    = 3'd3;
            mask = MASK_3;
         end else begin
            n    = 3'd4;
            mask = MASK_4;
         end
         if (buf_end) begin
            t.has_result          = 1'b1;
            t.result.byte_count   = 3'd1;
            t.result.is_error     = 1'b1;
            t.result.last_of_run  = 1'b1;
         end else begin
            t.seq.bytes_needed    = n;
            t.seq.bytes_seen      = 3'd1;
            t.seq.lead_byte       = b;
            t.seq.partial_value   = {13'd0, b & mask};
         end
      end
      return t;
   endfunction

endpackage

`default_nettype wire

>>> rtl/u8dec_step.sv
// Per-byte decode step: open sequence plus one byte gives up to two results
// and the next sequence state. Purely combinational; depends on u8dec_pkg.
`default_nettype none

module u8dec_step (
   input  wire u8dec_pkg::seq_state_type seq,
   input  wire logic [7:0]               data_byte,
   input  wire logic                     buffer_end,
   output u8dec_pkg::result_type         res0,
   output u8dec_pkg::result_type         res1,
   output logic [1:0]                    res_count,
   output u8dec_pkg::seq_state_type      seq_next
);

   u8dec_pkg::lead_type lead;
   logic                cont_ok;
   logic [20:0]         pv_shift;
   logic [2:0]          seen_inc;

   always_comb begin
      lead     = u8dec_pkg::take_lead(data_byte, buffer_end);
      cont_ok  = (seq.bytes_seen == 3'd1) ? u8dec_pkg::second_ok(seq.lead_byte, data_byte)
                                          : (data_byte[7:6] == u8dec_pkg::CONT_TAG);
      pv_shift = {seq.partial_value[14:0], data_byte[5:0]};
      seen_inc = seq.bytes_seen + 3'd1;

      res0      = '0;
      res1      = '0;
      res_count = 2'd0;
      seq_next  = '0;

      if (seq.bytes_needed == 3'd0) begin
         res0      = lead.result;
         res_count = {1'b0, lead.has_result};
         seq_next  = lead.seq;
      end else if (!cont_ok) begin
         // error for the broken sequence, then the byte again as a lead
         res0.byte_count  = seq.bytes_seen;
         res0.is_error    = 1'b1;
         res0.last_of_run = !lead.has_result;
         res1             = lead.result;
         res_count        = lead.has_result ? 2'd2 : 2'd1;
         seq_next         = lead.seq;
      end else if (seen_inc >= seq.bytes_needed) begin
         res0.code_point  = pv_shift;
         res0.byte_count  = seq.bytes_needed;
         res0.last_of_run = 1'b1;
         res_count        = 2'd1;
      end else if (buffer_end) begin
         res0.byte_count  = seen_inc;
         res0.is_error    = 1'b1;
         res0.last_of_run = 1'b1;
         res_count        = 2'd1;
      end else begin
         seq_next.bytes_needed  = seq.bytes_needed;
         seq_next.bytes_seen    = seen_inc;
         seq_next.lead_byte     = seq.lead_byte;
         seq_next.partial_value = pv_shift;
      end
   end

endmodule

`default_nettype wire

>>> rtl/u8dec_rspq.sv
// Result queue: takes zero, one or two results a cycle, hands out one while pop_ready is high.
// Depends on u8dec_pkg.
`default_nettype none

module u8dec_rspq (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [1:0]            push_count,
   input  wire u8dec_pkg::result_type push0,
   input  wire u8dec_pkg::result_type push1,
   output logic                       room,
   input  wire logic                  pop_ready,
   output logic                       out_valid,
   output u8dec_pkg::result_type      out_result
);

   localparam int unsigned CW = u8dec_pkg::Q_AW + 1;

   u8dec_pkg::result_type         entry_ff [u8dec_pkg::Q_DEPTH];
   logic [u8dec_pkg::Q_AW-1:0]    head_ff;
   logic [u8dec_pkg::Q_AW-1:0]    head_in;
   logic [CW-1:0]                 count_ff;
   logic [CW-1:0]                 count_in;
   logic [u8dec_pkg::Q_AW-1:0]    tail;
   logic [u8dec_pkg::Q_AW-1:0]    tail_next;
   logic                          pop;

   always_comb begin
      out_valid  = (count_ff != '0);
      out_result = entry_ff[head_ff];
      pop        = out_valid && pop_ready;
      room       = (count_ff <= CW'(u8dec_pkg::Q_DEPTH - 2));
      tail       = head_ff + count_ff[u8dec_pkg::Q_AW-1:0];
      tail_next  = tail + u8dec_pkg::Q_AW'(1);
      head_in    = pop ? head_ff + u8dec_pkg::Q_AW'(1) : head_ff;
      count_in   = count_ff + CW'(push_count) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[tail] <= push0;
      end
      if (push_count == 2'd2) begin
         entry_ff[tail_next] <= push1;
      end
   end

endmodule

`default_nettype wire

>>> rtl/utf8_validating_decoder_core.sv
// Top level of the UTF-8 validating decoder: input register, decode step,
// result queue. Depends on u8dec_pkg, u8dec_step and u8dec_rspq.
//
//  channel | ports                                         | direction
//  --------+-----------------------------------------------+----------
//  req     | req_valid/ready, req_data_byte, req_buffer_end | in
//  rsp     | rsp_valid/ready, rsp_code_point, rsp_byte_count,| out
//          | rsp_is_error, rsp_last_of_run                 |
//
// One byte per cycle is taken while the input register is empty or the
// queue has room; its result passes the input register, then the result
// queue, before rsp offers it. A byte that yields two results (broken
// sequence plus the retried lead) gives two; the 4-entry queue absorbs that.
// The input register moves a byte into the decoder only while the queue has
// room for two results, so req_ready never depends on rsp_ready directly.
// Synchronous reset closes any open sequence and empties the queue.
`default_nettype none

module utf8_validating_decoder_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_buffer_end,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [20:0]      rsp_code_point,
   output logic [2:0]       rsp_byte_count,
   output logic             rsp_is_error,
   output logic             rsp_last_of_run
);

   // input register
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;

   // open sequence
   u8dec_pkg::seq_state_type seq_ff;
   u8dec_pkg::seq_state_type seq_in;
   u8dec_pkg::seq_state_type step_next;

   u8dec_pkg::result_type res0;
   u8dec_pkg::result_type res1;
   u8dec_pkg::result_type q_out;
   logic [1:0]            res_count;
   logic [1:0]            push_count;
   logic                  q_room;
   logic                  consume;
   logic                  req_take;

   always_comb begin
      consume     = in_valid_ff && q_room;
      req_ready   = !in_valid_ff || q_room;
      req_take    = req_valid && req_ready;
      in_valid_in = req_take ? 1'b1 : (consume ? 1'b0 : in_valid_ff);
      seq_in      = consume ? step_next : seq_ff;
      push_count  = consume ? res_count : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         seq_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         seq_ff      <= seq_in;
      end
   end

   // payload only, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_data_byte;
         in_end_ff  <= req_buffer_end;
      end
   end

   u8dec_step u_step (
      .seq        (seq_ff),
      .data_byte  (in_byte_ff),
      .buffer_end (in_end_ff),
      .res0       (res0),
      .res1       (res1),
      .res_count  (res_count),
      .seq_next   (step_next)
   );

   u8dec_rspq u_rspq (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push0      (res0),
      .push1      (res1),
      .room       (q_room),
      .pop_ready  (rsp_ready),
      .out_valid  (rsp_valid),
      .out_result (q_out)
   );

   assign rsp_code_point  = q_out.code_point;
   assign rsp_byte_count  = q_out.byte_count;
   assign rsp_is_error    = q_out.is_error;
   assign rsp_last_of_run = q_out.last_of_run;

endmodule

`default_nettype wire

>>> rtl/u8dec_check.sv
// Port-level checker for the UTF-8 decoder, bound to the top level.
// Depends on utf8_validating_decoder_core_defines.svh.
`default_nettype none
`include "utf8_validating_decoder_core_defines.svh"

module u8dec_check (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [20:0] rsp_code_point,
   input wire logic [2:0]  rsp_byte_count,
   input wire logic        rsp_is_error
);

   // a stalled transaction holds
   `U8DEC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_code_point) && $stable(rsp_byte_count))

   `U8DEC_ASSERT_NOW(a_err_zero, clock, reset, rsp_valid && rsp_is_error, rsp_code_point == 21'd0)

   `U8DEC_ASSERT_NOW(a_count_range, clock, reset, rsp_valid, (rsp_byte_count != 3'd0) && (rsp_byte_count <= 3'd4))

   `U8DEC_ASSERT_NOW(a_ascii, clock, reset, rsp_valid && !rsp_is_error && (rsp_byte_count == 3'd1), rsp_code_point < 21'h80)

   `U8DEC_ASSERT_NOW(a_four_byte, clock, reset, rsp_valid && !rsp_is_error && (rsp_byte_count == 3'd4), (rsp_code_point >= 21'h10000) && (rsp_code_point <= 21'h10FFFF))

endmodule

bind utf8_validating_decoder_core u8dec_check u_u8dec_check (.*);

`default_nettype wire
